>>> rtl/union_find_connectivity_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the union-find connectivity core
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_CONNECTIVITY_CORE_MACROS_SVH
`define UNION_FIND_CONNECTIVITY_CORE_MACROS_SVH

// Check a property on every rising edge outside reset
`define UFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset
`define UFC_ASSERT_NEVER(lbl, cond, msg) \
  `UFC_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared widths and operation codes of the union-find connectivity core.
// ----------------------------------------------------------------------------
package ufc_pkg;

  // Node index field width on the stream
  localparam int unsigned NODE_W      = 10;

  // Stream payload widths (tdata in whole bytes)
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 8;

  // Operation codes carried in tuser
  localparam logic OP_UNION = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

>>> rtl/ufc_ram.sv
// ----------------------------------------------------------------------------
// ufc_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module ufc_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ufc_ctrl.sv
// ----------------------------------------------------------------------------
// ufc_ctrl
// Sequencer of the union-find core: clears the stores after reset, walks
// parent links to the root, compresses the walked path, then merges or
// compares the two roots.
// ----------------------------------------------------------------------------
`include "union_find_connectivity_core_macros.svh"

module ufc_ctrl
  import ufc_pkg::*;
#(
  parameter int unsigned NODES = 1024,
  localparam int unsigned IW   = $clog2(NODES),
  localparam int unsigned SW   = $clog2(NODES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  input  logic [NODE_W-1:0] in_node_a_i,
  input  logic [NODE_W-1:0] in_node_b_i,
  // result towards the output register
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              res_answer_o,
  // parent store
  output logic              p_we_o,
  output logic [IW-1:0]     p_waddr_o,
  output logic [IW-1:0]     p_wdata_o,
  output logic              p_re_o,
  output logic [IW-1:0]     p_raddr_o,
  input  logic [IW-1:0]     p_rdata_i,
  // set size store
  output logic              s_we_o,
  output logic [IW-1:0]     s_waddr_o,
  output logic [SW-1:0]     s_wdata_o,
  output logic              s_re_o,
  output logic [IW-1:0]     s_raddr_o,
  input  logic [SW-1:0]     s_rdata_i
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_FIND    = 3'd2;
  localparam logic [2:0] S_COMP    = 3'd3;
  localparam logic [2:0] S_RESOLVE = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  localparam logic [IW-1:0] LAST_NODE = IW'(NODES - 1);

  // control state
  logic [2:0]    state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  logic          side_q, side_d;
  logic          hopped_q, hopped_d;
  logic          deep_q, deep_d;
  logic          szcap_q, szcap_d;

  // payload state
  logic          op_q, op_d;
  logic          ans_q, ans_d;
  logic [IW-1:0] node_b_q, node_b_d;
  logic [IW-1:0] start_q, start_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] hop1_q, hop1_d;
  logic [IW-1:0] root_q, root_d;
  logic [IW-1:0] ra_q, ra_d;
  logic [SW-1:0] sz_a_q, sz_a_d;

  logic          in_range;
  logic          side_done;
  logic [IW-1:0] done_root;
  logic [SW-1:0] sz_sum;

  assign in_range = (32'(in_node_a_i) < 32'(NODES)) && (32'(in_node_b_i) < 32'(NODES));
  assign sz_sum   = sz_a_q + s_rdata_i;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    side_d    = side_q;
    hopped_d  = hopped_q;
    deep_d    = deep_q;
    szcap_d   = 1'b0;
    op_d      = op_q;
    ans_d     = ans_q;
    node_b_d  = node_b_q;
    start_d   = start_q;
    cur_d     = cur_q;
    hop1_d    = hop1_q;
    root_d    = root_q;
    ra_d      = ra_q;
    sz_a_d    = szcap_q ? s_rdata_i : sz_a_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    p_we_o      = 1'b0;
    p_waddr_o   = cur_q;
    p_wdata_o   = root_q;
    p_re_o      = 1'b0;
    p_raddr_o   = cur_q;
    s_we_o      = 1'b0;
    s_waddr_o   = ra_q;
    s_wdata_o   = sz_sum;
    s_re_o      = 1'b0;
    s_raddr_o   = cur_q;

    side_done = 1'b0;
    done_root = root_q;

    unique case (state_q)
      S_CLEAR: begin
        // sweep every entry to its own root with a set size of one
        p_we_o    = 1'b1;
        p_waddr_o = clr_q;
        p_wdata_o = clr_q;
        s_we_o    = 1'b1;
        s_waddr_o = clr_q;
        s_wdata_o = SW'(1);
        if (clr_q == LAST_NODE) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IW'(1);
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = in_op_i;
          node_b_d = IW'(in_node_b_i);
          start_d  = IW'(in_node_a_i);
          cur_d    = IW'(in_node_a_i);
          side_d   = 1'b0;
          hopped_d = 1'b0;
          deep_d   = 1'b0;
          if (in_range) begin
            p_re_o    = 1'b1;
            p_raddr_o = IW'(in_node_a_i);
            state_d   = S_FIND;
          end else begin
            ans_d   = 1'b0;
            state_d = S_DONE;
          end
        end
      end

      S_FIND: begin
        if (p_rdata_i == cur_q) begin
          // root reached: fetch its set size
          root_d    = cur_q;
          s_re_o    = 1'b1;
          s_raddr_o = cur_q;
          szcap_d   = !side_q;
          if (deep_q) begin
            // start node goes straight to the root, then walk on from its first hop
            p_we_o    = 1'b1;
            p_waddr_o = start_q;
            p_wdata_o = cur_q;
            p_re_o    = 1'b1;
            p_raddr_o = hop1_q;
            cur_d     = hop1_q;
            state_d   = S_COMP;
          end else begin
            side_done = 1'b1;
            done_root = cur_q;
          end
        end else begin
          // follow the parent link
          cur_d     = p_rdata_i;
          p_re_o    = 1'b1;
          p_raddr_o = p_rdata_i;
          if (hopped_q) begin
            deep_d = 1'b1;
          end else begin
            hop1_d   = p_rdata_i;
            hopped_d = 1'b1;
          end
        end
      end

      S_COMP: begin
        // re-point the current node at the root
        p_we_o    = 1'b1;
        p_waddr_o = cur_q;
        p_wdata_o = root_q;
        if (p_rdata_i == root_q) begin
          side_done = 1'b1;
          done_root = root_q;
        end else begin
          cur_d     = p_rdata_i;
          p_re_o    = 1'b1;
          p_raddr_o = p_rdata_i;
        end
      end

      S_RESOLVE: begin
        // root of a in ra_q, root of b in root_q, size of b on the read port
        if (op_q == OP_QUERY) begin
          ans_d = (ra_q == root_q);
        end else if (ra_q != root_q) begin
          ans_d  = 1'b1;
          p_we_o = 1'b1;
          s_we_o = 1'b1;
          if (sz_a_q < s_rdata_i) begin
            p_waddr_o = ra_q;
            p_wdata_o = root_q;
            s_waddr_o = root_q;
          end else begin
            p_waddr_o = root_q;
            p_wdata_o = ra_q;
            s_waddr_o = ra_q;
          end
        end else begin
          ans_d = 1'b0;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance to node b, or on to the merge or compare once both roots are known
    if (side_done) begin
      if (!side_q) begin
        ra_d      = done_root;
        side_d    = 1'b1;
        start_d   = node_b_q;
        cur_d     = node_b_q;
        hopped_d  = 1'b0;
        deep_d    = 1'b0;
        p_re_o    = 1'b1;
        p_raddr_o = node_b_q;
        state_d   = S_FIND;
      end else begin
        state_d = S_RESOLVE;
      end
    end
  end

  assign res_answer_o = ans_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      side_q   <= 1'b0;
      hopped_q <= 1'b0;
      deep_q   <= 1'b0;
      szcap_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      side_q   <= side_d;
      hopped_q <= hopped_d;
      deep_q   <= deep_d;
      szcap_q  <= szcap_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    ans_q    <= ans_d;
    node_b_q <= node_b_d;
    start_q  <= start_d;
    cur_q    <= cur_d;
    hop1_q   <= hop1_d;
    root_q   <= root_d;
    ra_q     <= ra_d;
    sz_a_q   <= sz_a_d;
  end

  `UFC_ASSERT(a_merge_distinct_roots, (state_q == S_RESOLVE && p_we_o) |-> (op_q == OP_UNION && ra_q != root_q), "merge written for a query or for one root")
  `UFC_ASSERT(a_compress_to_root, (state_q == S_COMP) |-> (p_we_o && p_wdata_o == root_q), "path compression not pointing at the root")
  `UFC_ASSERT(a_size_grows, (state_q == S_RESOLVE && s_we_o) |-> (s_wdata_o > sz_a_q && s_wdata_o > s_rdata_i), "merged set size overflowed")
  `UFC_ASSERT(a_out_of_range_zero, (in_valid_i && in_ready_o && !in_range) |=> (state_q == S_DONE && !ans_q), "out-of-range item not answered with zero")

endmodule

>>> rtl/union_find_connectivity_core.sv
// ----------------------------------------------------------------------------
// union_find_connectivity_core
// Disjoint-set union over NODES elements, union by size with full path
// compression, one result item for each input item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: tuser = op (union or query), tdata = node_a and
//   node_b. m_axis returns one item per input: tdata bit 0 = answer.
//   After reset the core sweeps both stores, one entry per cycle, with
//   s_axis_tready low; then every node is its own set of one.
//   An item walks the parent hops from node_a and then node_b to their
//   roots, one hop at a time on the single read port of the parent store,
//   and walks a path of more than one hop again to re-point it at the root.
//   An item with a node outside the range answers 0 without touching the
//   stores.
//   The result enters an output register at the edge at which the core turns
//   ready again, so the next item is taken while that result still waits. A
//   stalled m_axis holds the register; a second finished result then waits
//   inside the core, and s_axis_tready stays low until it is passed on.
// ----------------------------------------------------------------------------
module union_find_connectivity_core
  import ufc_pkg::*;
#(
  parameter int unsigned NODES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] node_a, [19:10] node_b
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [0] op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] answer
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned SW = $clog2(NODES + 1);

  logic          res_valid;
  logic          res_ready;
  logic          res_answer;

  logic          p_we, p_re;
  logic [IW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic          s_we, s_re;
  logic [IW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;

  logic          out_valid_q, out_valid_d;
  logic          out_ans_q, out_ans_d;

  ufc_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser[0]),
    .in_node_a_i  (s_axis_tdata[NODE_W-1:0]),
    .in_node_b_i  (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_answer_o (res_answer),
    .p_we_o       (p_we),
    .p_waddr_o    (p_waddr),
    .p_wdata_o    (p_wdata),
    .p_re_o       (p_re),
    .p_raddr_o    (p_raddr),
    .p_rdata_i    (p_rdata),
    .s_we_o       (s_we),
    .s_waddr_o    (s_waddr),
    .s_wdata_o    (s_wdata),
    .s_re_o       (s_re),
    .s_raddr_o    (s_raddr),
    .s_rdata_i    (s_rdata)
  );

  ufc_ram #(
    .DEPTH (NODES),
    .WIDTH (IW)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  ufc_ram #(
    .DEPTH (NODES),
    .WIDTH (SW)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Output register: load when empty or being drained, drop once taken
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_ans_d   = out_ans_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_ans_d   = res_answer;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ans_q <= out_ans_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_ans_q};

endmodule
